>>> sv/dmip_pkg.sv
`default_nettype none

package dmip_pkg;

    // Field widths
    localparam int ACT_W     = 2;
    localparam int CNT_W     = 16;
    localparam int DIR_W     = 3;
    localparam int TGT_W     = 14;
    localparam int BUD_IN_W  = 24;
    localparam int BUD_W     = 32;
    localparam int GAIN_W    = 14;
    localparam int ERR_W     = 18;
    localparam int DUTY_W    = 32;
    localparam int OUT_W     = 16;
    localparam int PINS_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths of one wheel lane
    localparam int SUM_W     = 36;
    localparam int MAG_W     = 33;
    localparam int HALF_W    = 17;
    localparam int PRD_W     = 67;
    localparam int QUO_W     = 24;
    localparam int K_W       = QUO_W + 1;

    // Pipeline registers between the input and the output register
    localparam int STAGES    = 7;

    // Stream word layout
    localparam int S_TDATA_W     = 112;
    localparam int S_CNT_A_LSB   = 0;
    localparam int S_CNT_B_LSB   = 16;
    localparam int S_DIR_LSB     = 32;
    localparam int S_TGT_A_LSB   = 35;
    localparam int S_TGT_B_LSB   = 49;
    localparam int S_BUD_A_LSB   = 63;
    localparam int S_BUD_B_LSB   = 87;

    localparam int M_TDATA_W     = 72;
    localparam int M_DUTY_A_LSB  = 0;
    localparam int M_DUTY_B_LSB  = 16;
    localparam int M_PINS_LSB    = 32;
    localparam int M_SPEED_A_LSB = 36;
    localparam int M_SPEED_B_LSB = 52;
    localparam int M_MOVING_BIT  = 68;
    localparam int M_DONE_BIT    = 69;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SPEED = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE  = 2'd2;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_HALT   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_FWD    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_TURN_L = 3'd3;
    localparam logic [DIR_W-1:0] DIR_TURN_R = 3'd4;

    // Bridge pin levels, A1 A2 B1 B2 from the top bit down
    localparam logic [PINS_W-1:0] PINS_STOP  = 4'b1111;
    localparam logic [PINS_W-1:0] PINS_FWD   = 4'b1001;
    localparam logic [PINS_W-1:0] PINS_BACK  = 4'b0110;
    localparam logic [PINS_W-1:0] PINS_LEFT  = 4'b0101;
    localparam logic [PINS_W-1:0] PINS_RIGHT = 4'b1010;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_P_RST = 14'd400;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 14'd800;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 14'd100;

    localparam logic [CNT_W-1:0] FOLD_LIMIT = 16'd10000;
    localparam logic [CNT_W-1:0] CNT_MAX    = 16'hFFFF;
    localparam logic [OUT_W-1:0] DUTY_MAX   = 16'hFFFF;

    // floor(n / 1000) = (n * RECIP) >> RECIP_SHIFT, exact for n below 2^33
    localparam logic [9:0]          DIVISOR     = 10'd1000;
    localparam int                  RECIP_SHIFT = 43;
    localparam logic [33:0]         RECIP       = 34'd8796093023;
    localparam logic [HALF_W-1:0]   RECIP_HI    = RECIP[33:17];
    localparam logic [HALF_W-1:0]   RECIP_LO    = RECIP[16:0];

    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
    } err_set_t;

    typedef struct packed {
        logic              is_tick;
        logic              stop;
        logic [PINS_W-1:0] pins;
        logic [CNT_W-1:0]  speed_a;
        logic [CNT_W-1:0]  speed_b;
        logic              moving;
        logic              done;
    } side_t;

    typedef struct packed {
        logic p1;
        logic p2;
        logic p3;
        logic p4;
        logic p5;
        logic p6;
        logic p7;
    } stage_ld_t;

endpackage

`default_nettype wire

>>> sv/dmip_ctrl.sv
`default_nettype none

module dmip_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [dmip_pkg::ACT_W-1:0]    action,
    input  logic [dmip_pkg::CNT_W-1:0]    count_a,
    input  logic [dmip_pkg::CNT_W-1:0]    count_b,
    input  logic [dmip_pkg::DIR_W-1:0]    direction,
    input  logic [dmip_pkg::TGT_W-1:0]    target_a,
    input  logic [dmip_pkg::TGT_W-1:0]    target_b,
    input  logic [dmip_pkg::BUD_IN_W-1:0] budget_a,
    input  logic [dmip_pkg::BUD_IN_W-1:0] budget_b,
    output dmip_pkg::err_set_t            err_a,
    output dmip_pkg::err_set_t            err_b,
    output dmip_pkg::side_t               side
);

    logic [dmip_pkg::TGT_W-1:0]        tgt_a_reg, tgt_a_next;
    logic [dmip_pkg::TGT_W-1:0]        tgt_b_reg, tgt_b_next;
    logic signed [dmip_pkg::BUD_W-1:0] bud_a_reg, bud_a_next;
    logic signed [dmip_pkg::BUD_W-1:0] bud_b_reg, bud_b_next;
    logic [dmip_pkg::DIR_W-1:0]        dir_reg, dir_next;
    logic                              move_reg, move_next;
    dmip_pkg::err_set_t                hist_a_reg, hist_a_next;
    dmip_pkg::err_set_t                hist_b_reg, hist_b_next;
    logic [dmip_pkg::CNT_W-1:0]        spd_a, spd_b;
    logic                              done;
    logic                              stop;
    logic                              tick;

    function automatic logic [dmip_pkg::PINS_W-1:0] pins_of(
        input logic [dmip_pkg::DIR_W-1:0] d
    );
        logic [dmip_pkg::PINS_W-1:0] p;
        unique case (d)
            dmip_pkg::DIR_FWD:    p = dmip_pkg::PINS_FWD;
            dmip_pkg::DIR_BACK:   p = dmip_pkg::PINS_BACK;
            dmip_pkg::DIR_TURN_L: p = dmip_pkg::PINS_LEFT;
            dmip_pkg::DIR_TURN_R: p = dmip_pkg::PINS_RIGHT;
            default:              p = dmip_pkg::PINS_STOP;
        endcase
        return p;
    endfunction

    // Counts at or above the limit are taken as a reverse-running encoder.
    function automatic logic [dmip_pkg::CNT_W-1:0] fold(
        input logic [dmip_pkg::CNT_W-1:0] c
    );
        return (c < dmip_pkg::FOLD_LIMIT) ? c : dmip_pkg::CNT_MAX - c;
    endfunction

    function automatic logic signed [dmip_pkg::BUD_W-1:0] sub_sat(
        input logic signed [dmip_pkg::BUD_W-1:0] b,
        input logic [dmip_pkg::CNT_W-1:0]        s
    );
        logic signed [dmip_pkg::BUD_W:0] r;
        r = {b[dmip_pkg::BUD_W-1], b}
            - {{(dmip_pkg::BUD_W + 1 - dmip_pkg::CNT_W){1'b0}}, s};
        // The difference can only leave the range at the negative end.
        if (r[dmip_pkg::BUD_W] != r[dmip_pkg::BUD_W-1]) begin
            return {1'b1, {(dmip_pkg::BUD_W - 1){1'b0}}};
        end
        return r[dmip_pkg::BUD_W-1:0];
    endfunction

    function automatic logic signed [dmip_pkg::ERR_W-1:0] err_of(
        input logic [dmip_pkg::TGT_W-1:0] t,
        input logic [dmip_pkg::CNT_W-1:0] s
    );
        return signed'({{(dmip_pkg::ERR_W - dmip_pkg::TGT_W){1'b0}}, t})
             - signed'({{(dmip_pkg::ERR_W - dmip_pkg::CNT_W){1'b0}}, s});
    endfunction

    always_comb begin
        tgt_a_next  = tgt_a_reg;
        tgt_b_next  = tgt_b_reg;
        bud_a_next  = bud_a_reg;
        bud_b_next  = bud_b_reg;
        dir_next    = dir_reg;
        move_next   = move_reg;
        hist_a_next = hist_a_reg;
        hist_b_next = hist_b_reg;
        done        = 1'b0;
        stop        = 1'b0;
        tick        = 1'b0;
        spd_a       = fold(count_a);
        spd_b       = fold(count_b);

        unique case (action)
            dmip_pkg::ACT_SPEED, dmip_pkg::ACT_MOVE: begin
                dir_next   = direction;
                tgt_a_next = target_a;
                tgt_b_next = target_b;
                if (action == dmip_pkg::ACT_MOVE) begin
                    bud_a_next = signed'({{(dmip_pkg::BUD_W - dmip_pkg::BUD_IN_W){1'b0}},
                                          budget_a});
                    bud_b_next = signed'({{(dmip_pkg::BUD_W - dmip_pkg::BUD_IN_W){1'b0}},
                                          budget_b});
                    move_next  = 1'b1;
                end
            end
            dmip_pkg::ACT_TICK: begin
                tick = 1'b1;
                // Wheel A out of distance drops its target; both out ends the move.
                if (bud_a_reg < 0) begin
                    tgt_a_next = '0;
                    if (bud_b_reg < 0) begin
                        bud_a_next = '0;
                        bud_b_next = '0;
                        tgt_b_next = '0;
                        move_next  = 1'b0;
                        done       = 1'b1;
                        dir_next   = dmip_pkg::DIR_HALT;
                    end
                end
                if (dir_next == dmip_pkg::DIR_HALT) begin
                    tgt_a_next = '0;
                    tgt_b_next = '0;
                    stop       = 1'b1;
                end
                hist_a_next.e0 = err_of(tgt_a_next, spd_a);
                hist_a_next.e1 = hist_a_reg.e0;
                hist_a_next.e2 = hist_a_reg.e1;
                hist_b_next.e0 = err_of(tgt_b_next, spd_b);
                hist_b_next.e1 = hist_b_reg.e0;
                hist_b_next.e2 = hist_b_reg.e1;
                if (move_next) begin
                    bud_a_next = sub_sat(bud_a_next, spd_a);
                    bud_b_next = sub_sat(bud_b_next, spd_b);
                end
            end
            default: begin
            end
        endcase

        side.is_tick = tick;
        side.stop    = stop;
        side.pins    = pins_of(dir_next);
        side.speed_a = tick ? spd_a : '0;
        side.speed_b = tick ? spd_b : '0;
        side.moving  = move_next;
        side.done    = done;
    end

    assign err_a = hist_a_next;
    assign err_b = hist_b_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_a_reg  <= '0;
            tgt_b_reg  <= '0;
            bud_a_reg  <= '0;
            bud_b_reg  <= '0;
            dir_reg    <= dmip_pkg::DIR_HALT;
            move_reg   <= 1'b0;
            hist_a_reg <= '0;
            hist_b_reg <= '0;
        end else if (accept) begin
            tgt_a_reg  <= tgt_a_next;
            tgt_b_reg  <= tgt_b_next;
            bud_a_reg  <= bud_a_next;
            bud_b_reg  <= bud_b_next;
            dir_reg    <= dir_next;
            move_reg   <= move_next;
            hist_a_reg <= hist_a_next;
            hist_b_reg <= hist_b_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/dmip_lane.sv
`default_nettype none

module dmip_lane (
    input  logic                            aclk,
    input  dmip_pkg::stage_ld_t             ld,
    input  logic [dmip_pkg::GAIN_W-1:0]     gain_p,
    input  logic [dmip_pkg::GAIN_W-1:0]     gain_i,
    input  logic [dmip_pkg::GAIN_W-1:0]     gain_d,
    input  dmip_pkg::err_set_t              err_in,
    output logic signed [dmip_pkg::K_W-1:0] quo_floor,
    output logic                            rem_nz
);

    localparam int D1_W = dmip_pkg::ERR_W + 1;
    localparam int D2_W = dmip_pkg::ERR_W + 2;
    localparam int G_W  = dmip_pkg::GAIN_W + 1;
    localparam int NH_W = dmip_pkg::MAG_W - dmip_pkg::HALF_W;

    dmip_pkg::err_set_t err_reg;

    logic signed [D1_W-1:0] d1;
    logic signed [D2_W-1:0] d2;
    logic signed [G_W-1:0]  gp_s, gi_s, gd_s;

    logic signed [G_W+D1_W-1:0]           t1_reg, t1_next;
    logic signed [G_W+dmip_pkg::ERR_W-1:0] t2_reg, t2_next;
    logic signed [G_W+D2_W-1:0]           t3_reg, t3_next;

    logic signed [dmip_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [dmip_pkg::SUM_W-1:0] sum_abs;

    logic                        neg4_reg;
    logic [dmip_pkg::MAG_W-1:0]  mag4_reg;

    logic [NH_W-1:0]             mag_hi;
    logic [dmip_pkg::HALF_W-1:0] mag_lo;
    logic [NH_W+dmip_pkg::HALF_W-1:0]           pp_hh_reg, pp_hh_next;
    logic [NH_W+dmip_pkg::HALF_W-1:0]           pp_hl_reg, pp_hl_next;
    logic [2*dmip_pkg::HALF_W-1:0]              pp_lh_reg, pp_lh_next;
    logic [2*dmip_pkg::HALF_W-1:0]              pp_ll_reg, pp_ll_next;
    logic                        neg5_reg;
    logic [dmip_pkg::MAG_W-1:0]  mag5_reg;

    logic [dmip_pkg::PRD_W-1:0]  prod;
    logic [dmip_pkg::QUO_W-1:0]  quo6_reg;
    logic                        neg6_reg;
    logic [dmip_pkg::MAG_W-1:0]  mag6_reg;

    logic [dmip_pkg::MAG_W:0]        back;
    logic                            rnz;
    logic signed [dmip_pkg::K_W-1:0] quo_ext;
    logic signed [dmip_pkg::K_W-1:0] k_next;
    logic signed [dmip_pkg::K_W-1:0] k_reg;
    logic                            rnz_reg;

    assign gp_s = signed'({1'b0, gain_p});
    assign gi_s = signed'({1'b0, gain_i});
    assign gd_s = signed'({1'b0, gain_d});

    // Incremental PID terms on the error history.
    assign d1 = D1_W'(err_reg.e0) - D1_W'(err_reg.e1);
    assign d2 = D2_W'(err_reg.e0) - (D2_W'(err_reg.e1) <<< 1) + D2_W'(err_reg.e2);
    assign t1_next = gp_s * d1;
    assign t2_next = gi_s * err_reg.e0;
    assign t3_next = gd_s * d2;

    assign sum_next = dmip_pkg::SUM_W'(t1_reg) + dmip_pkg::SUM_W'(t2_reg)
                    + dmip_pkg::SUM_W'(t3_reg);

    // With 14-bit gains and errors between -55535 and 16383 the sum stays below 2^33 in magnitude.
    assign sum_abs = sum_reg[dmip_pkg::SUM_W-1] ? -sum_reg : sum_reg;

    // Magnitude times the reciprocal of 1000, split into four partial products.
    assign mag_hi     = mag4_reg[dmip_pkg::MAG_W-1:dmip_pkg::HALF_W];
    assign mag_lo     = mag4_reg[dmip_pkg::HALF_W-1:0];
    assign pp_hh_next = mag_hi * dmip_pkg::RECIP_HI;
    assign pp_hl_next = mag_hi * dmip_pkg::RECIP_LO;
    assign pp_lh_next = mag_lo * dmip_pkg::RECIP_HI;
    assign pp_ll_next = mag_lo * dmip_pkg::RECIP_LO;

    assign prod = (dmip_pkg::PRD_W'(pp_hh_reg) << (2 * dmip_pkg::HALF_W))
                + (dmip_pkg::PRD_W'(pp_hl_reg) << dmip_pkg::HALF_W)
                + (dmip_pkg::PRD_W'(pp_lh_reg) << dmip_pkg::HALF_W)
                + dmip_pkg::PRD_W'(pp_ll_reg);

    // Turn the magnitude quotient into a floor quotient of the signed sum.
    assign back    = (dmip_pkg::MAG_W + 1)'(quo6_reg) * (dmip_pkg::MAG_W + 1)'(dmip_pkg::DIVISOR);
    assign rnz     = (back[dmip_pkg::MAG_W-1:0] != mag6_reg);
    assign quo_ext = signed'({1'b0, quo6_reg});
    assign k_next  = neg6_reg ? -(quo_ext + dmip_pkg::K_W'(rnz)) : quo_ext;

    always_ff @(posedge aclk) begin
        if (ld.p1) begin
            err_reg <= err_in;
        end
        if (ld.p2) begin
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
        end
        if (ld.p3) begin
            sum_reg <= sum_next;
        end
        if (ld.p4) begin
            neg4_reg <= sum_reg[dmip_pkg::SUM_W-1];
            mag4_reg <= sum_abs[dmip_pkg::MAG_W-1:0];
        end
        if (ld.p5) begin
            pp_hh_reg <= pp_hh_next;
            pp_hl_reg <= pp_hl_next;
            pp_lh_reg <= pp_lh_next;
            pp_ll_reg <= pp_ll_next;
            neg5_reg  <= neg4_reg;
            mag5_reg  <= mag4_reg;
        end
        if (ld.p6) begin
            quo6_reg <= prod[dmip_pkg::PRD_W-1:dmip_pkg::RECIP_SHIFT];
            neg6_reg <= neg5_reg;
            mag6_reg <= mag5_reg;
        end
        if (ld.p7) begin
            k_reg   <= k_next;
            rnz_reg <= rnz;
        end
    end

    assign quo_floor = k_reg;
    assign rem_nz    = rnz_reg;

endmodule

`default_nettype wire

>>> sv/dual_motor_incremental_pid.sv
// An accepted word passes the lane stages and the output register to m_tvalid.
// Throughput: one word per cycle unless m_tready stalls; the two wheels run in
// parallel seven-stage lanes and the duty accumulators update in one add-and-saturate
// step at the output. Reset (aresetn low at a clock edge) empties the pipeline,
// zeroes all controller state and loads the gains with 400, 800 and 100.
`default_nettype none

module dual_motor_incremental_pid (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // count_a, count_b, direction, target_a, target_b, budget_a, budget_b, pad
    input  logic [dmip_pkg::S_TDATA_W-1:0]      s_tdata,
    // action
    input  logic [dmip_pkg::ACT_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // duty_a, duty_b, bridge_pins, speed_a, speed_b, moving, move_done, pad
    output logic [dmip_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [dmip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmip_pkg::GAIN_W-1:0]         cfg_wr_data
);

    localparam int N = dmip_pkg::STAGES;

    logic [dmip_pkg::GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;

    logic [N-1:0] vld_reg, vld_next;
    logic [N-1:0] free;
    logic [N-1:0] load;
    logic         free_out, load_out;
    dmip_pkg::stage_ld_t ld;

    dmip_pkg::err_set_t err_a, err_b;
    dmip_pkg::side_t    side_in;
    dmip_pkg::side_t    side_reg [N];

    logic signed [dmip_pkg::K_W-1:0] k_a, k_b;
    logic                            rnz_a, rnz_b;

    logic signed [dmip_pkg::DUTY_W-1:0] duty_a_reg, duty_a_next;
    logic signed [dmip_pkg::DUTY_W-1:0] duty_b_reg, duty_b_next;

    logic                               m_tvalid_reg;
    logic [dmip_pkg::M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    // new duty = trunc((1000*d + s) / 1000) = d + k, plus one when that is negative and the
    // division left a remainder (k is floor(s / 1000); d is taken as zero on a stop tick).
    function automatic logic signed [dmip_pkg::DUTY_W-1:0] duty_step(
        input logic signed [dmip_pkg::DUTY_W-1:0] d,
        input logic                               zero,
        input logic signed [dmip_pkg::K_W-1:0]    k,
        input logic                               rnz
    );
        logic signed [dmip_pkg::DUTY_W:0] base;
        logic signed [dmip_pkg::DUTY_W:0] x;
        logic signed [dmip_pkg::DUTY_W:0] y;
        base = zero ? '0 : (dmip_pkg::DUTY_W + 1)'(d);
        x    = base + (dmip_pkg::DUTY_W + 1)'(k);
        y    = x + {{dmip_pkg::DUTY_W{1'b0}}, x[dmip_pkg::DUTY_W] & rnz};
        if (y[dmip_pkg::DUTY_W] != y[dmip_pkg::DUTY_W-1]) begin
            return y[dmip_pkg::DUTY_W] ? {1'b1, {(dmip_pkg::DUTY_W - 1){1'b0}}}
                                       : {1'b0, {(dmip_pkg::DUTY_W - 1){1'b1}}};
        end
        return y[dmip_pkg::DUTY_W-1:0];
    endfunction

    function automatic logic [dmip_pkg::OUT_W-1:0] clamp_duty(
        input logic signed [dmip_pkg::DUTY_W-1:0] d
    );
        if (d[dmip_pkg::DUTY_W-1]) begin
            return '0;
        end
        if (|d[dmip_pkg::DUTY_W-2:dmip_pkg::OUT_W]) begin
            return dmip_pkg::DUTY_MAX;
        end
        return d[dmip_pkg::OUT_W-1:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= dmip_pkg::GAIN_P_RST;
            gain_i_reg <= dmip_pkg::GAIN_I_RST;
            gain_d_reg <= dmip_pkg::GAIN_D_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dmip_pkg::CFG_GAIN_P: gain_p_reg <= cfg_wr_data;
                dmip_pkg::CFG_GAIN_I: gain_i_reg <= cfg_wr_data;
                dmip_pkg::CFG_GAIN_D: gain_d_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Each stage takes a new word when it is empty or its word moves on,
    // so bubbles close up even while the output is stalled.
    always_comb begin
        free_out    = !m_tvalid_reg || m_tready;
        load_out    = vld_reg[N-1] && free_out;
        free[N-1]   = !vld_reg[N-1] || free_out;
        for (int i = N - 2; i >= 0; i--) begin
            free[i] = !vld_reg[i] || free[i+1];
        end
        load[0]     = s_tvalid && free[0];
        vld_next[0] = free[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < N; i++) begin
            load[i]     = vld_reg[i-1] && free[i];
            vld_next[i] = free[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign ld.p1 = load[0];
    assign ld.p2 = load[1];
    assign ld.p3 = load[2];
    assign ld.p4 = load[3];
    assign ld.p5 = load[4];
    assign ld.p6 = load[5];
    assign ld.p7 = load[6];

    assign s_tready = free[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    dmip_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (load[0]),
        .action    (s_tuser),
        .count_a   (s_tdata[dmip_pkg::S_CNT_A_LSB +: dmip_pkg::CNT_W]),
        .count_b   (s_tdata[dmip_pkg::S_CNT_B_LSB +: dmip_pkg::CNT_W]),
        .direction (s_tdata[dmip_pkg::S_DIR_LSB +: dmip_pkg::DIR_W]),
        .target_a  (s_tdata[dmip_pkg::S_TGT_A_LSB +: dmip_pkg::TGT_W]),
        .target_b  (s_tdata[dmip_pkg::S_TGT_B_LSB +: dmip_pkg::TGT_W]),
        .budget_a  (s_tdata[dmip_pkg::S_BUD_A_LSB +: dmip_pkg::BUD_IN_W]),
        .budget_b  (s_tdata[dmip_pkg::S_BUD_B_LSB +: dmip_pkg::BUD_IN_W]),
        .err_a     (err_a),
        .err_b     (err_b),
        .side      (side_in)
    );

    dmip_lane u_lane_a (
        .aclk      (aclk),
        .ld        (ld),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .err_in    (err_a),
        .quo_floor (k_a),
        .rem_nz    (rnz_a)
    );

    dmip_lane u_lane_b (
        .aclk      (aclk),
        .ld        (ld),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .err_in    (err_b),
        .quo_floor (k_b),
        .rem_nz    (rnz_b)
    );

    // Sideband fields travel alongside the lane arithmetic.
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < N; i++) begin
            if (load[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb begin
        duty_a_next = duty_a_reg;
        duty_b_next = duty_b_reg;
        if (side_reg[N-1].is_tick) begin
            duty_a_next = duty_step(duty_a_reg, side_reg[N-1].stop, k_a, rnz_a);
            duty_b_next = duty_step(duty_b_reg, side_reg[N-1].stop, k_b, rnz_b);
        end
        m_tdata_next = '0;
        m_tdata_next[dmip_pkg::M_DUTY_A_LSB +: dmip_pkg::OUT_W]  = clamp_duty(duty_a_next);
        m_tdata_next[dmip_pkg::M_DUTY_B_LSB +: dmip_pkg::OUT_W]  = clamp_duty(duty_b_next);
        m_tdata_next[dmip_pkg::M_PINS_LSB +: dmip_pkg::PINS_W]   = side_reg[N-1].pins;
        m_tdata_next[dmip_pkg::M_SPEED_A_LSB +: dmip_pkg::CNT_W] = side_reg[N-1].speed_a;
        m_tdata_next[dmip_pkg::M_SPEED_B_LSB +: dmip_pkg::CNT_W] = side_reg[N-1].speed_b;
        m_tdata_next[dmip_pkg::M_MOVING_BIT]                      = side_reg[N-1].moving;
        m_tdata_next[dmip_pkg::M_DONE_BIT]                        = side_reg[N-1].done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_a_reg   <= '0;
            duty_b_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                duty_a_reg <= duty_a_next;
                duty_b_reg <= duty_b_next;
            end
            if (free_out) begin
                m_tvalid_reg <= vld_reg[N-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> sv/dmip_checker.sv
`default_nettype none

module dmip_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dmip_pkg::M_TDATA_W-1:0] m_tdata
);

    // Reset leaves no word on the output.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word present after reset");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // The tick that ends a move clears the move flag and drives the bridge to stop.
    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[dmip_pkg::M_DONE_BIT] |->
            !m_tdata[dmip_pkg::M_MOVING_BIT]
            && (m_tdata[dmip_pkg::M_PINS_LSB +: dmip_pkg::PINS_W] == dmip_pkg::PINS_STOP))
        else $error("move end without stop");

endmodule

bind dual_motor_incremental_pid dmip_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
